/* rtl/gcc_pkg.sv */
// ----------------------------------------------------------------------------
// gcc_pkg
// Shared types, codes and helpers of the graph colouring checker.
// ----------------------------------------------------------------------------
package gcc_pkg;

    localparam int ID_W      = 6;     // node id and colour index width
    localparam int NUM_W     = 7;     // num_nodes register width
    localparam int PAIRS_W   = 7;     // conflict_pairs width
    localparam int CNT_OUT_W = 12;    // width of the shown running totals
    localparam int CNT_OUT_MAX = 4095;
    localparam int NUM_RESET = 64;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_EDGE  = 2'd1,
        OP_PLACE = 2'd2,
        OP_CHECK = 2'd3
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch input word, issue memory reads
        logic exec;      // first execute step of the latched operation
        logic edge2;     // second row write of add edge
        logic count;     // finish popcount, commit a placement
        logic load;      // move result into the output register
    } gcc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic oor;
    } gcc_stat_t;

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] cnt;
        cnt = '0;
        for (int i = 0; i < 8; i++)
        begin
            cnt = cnt + 4'(v[i]);
        end
        return cnt;
    endfunction

endpackage

/* rtl/gcc_ctrl.sv */
// ----------------------------------------------------------------------------
// gcc_ctrl
// Sequencer of the checker: one word at a time, holds the result until the
// output register is free.
// ----------------------------------------------------------------------------
module gcc_ctrl
    import gcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic      out_stall,
    output logic      out_valid,
    output logic      cfg_ready,
    input  gcc_stat_t stat,
    output gcc_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_EDGE2,
        S_COUNT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd         = '0;
        cmd.capture = (state_reg == S_IDLE) && in_valid;
        cmd.exec    = (state_reg == S_EXEC);
        cmd.edge2   = (state_reg == S_EDGE2);
        cmd.count   = (state_reg == S_COUNT);
        cmd.load    = (state_reg == S_DONE) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (stat.op)
                    OP_EDGE:  state_next = stat.oor ? S_DONE : S_EDGE2;
                    OP_PLACE: state_next = stat.oor ? S_DONE : S_COUNT;
                    default:  state_next = S_DONE;
                endcase
            end
            S_EDGE2: state_next = S_DONE;
            S_COUNT: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/gcc_dp.sv */
// ----------------------------------------------------------------------------
// gcc_dp
// Datapath: adjacency and colour member memories, placement state, running
// totals and the result register.
// ----------------------------------------------------------------------------
module gcc_dp
    import gcc_pkg::*;
#(
    parameter int MAX_NODES   = 64,
    parameter int MAX_COLOURS = 64,
    parameter int COUNT_WIDTH = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  gcc_cmd_t             cmd,
    output gcc_stat_t            stat,
    input  logic                 cfg_we,
    input  logic [NUM_W-1:0]     cfg_data,
    input  logic [1:0]           operation,
    input  logic [ID_W-1:0]      node_a,
    input  logic [ID_W-1:0]      node_b,
    input  logic [ID_W-1:0]      colour,
    output logic                 out_of_range,
    output logic                 duplicate_edge,
    output logic [PAIRS_W-1:0]   conflict_pairs,
    output logic                 placed_again,
    output logic                 length_ok,
    output logic                 each_once_ok,
    output logic                 colouring_valid,
    output logic [CNT_OUT_W-1:0] clash_count,
    output logic [CNT_OUT_W-1:0] duplicate_edge_count
);

    localparam int NW   = $clog2(MAX_NODES);
    localparam int CW   = $clog2(MAX_COLOURS);
    localparam int NB   = (MAX_NODES + 7) / 8;
    localparam int PADW = NB * 8;
    localparam int SW   = (COUNT_WIDTH > CNT_OUT_W) ? COUNT_WIDTH : CNT_OUT_W;

    typedef logic [MAX_NODES-1:0]   row_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    // memories; a row whose valid bit is clear reads as its reset value
    row_t adj_mem [MAX_NODES];
    row_t col_mem [MAX_COLOURS];

    // control state
    logic [NUM_W-1:0]   num_nodes_reg, num_nodes_next;
    row_t               adj_vld_reg, adj_vld_next;
    logic [MAX_COLOURS-1:0] col_vld_reg, col_vld_next;
    row_t               once_reg, once_next;     // placed exactly once
    row_t               multi_reg, multi_next;   // placed two or more times
    count_t             clash_total_reg, clash_total_next;
    count_t             dup_total_reg, dup_total_next;
    count_t             placed_total_reg, placed_total_next;

    // payload
    op_t                op_reg;
    logic [ID_W-1:0]    a_reg, b_reg, c_reg;
    row_t               adj_a_rd_reg, adj_b_rd_reg, col_rd_reg;
    logic               adj_a_v_reg, adj_b_v_reg, col_v_reg;
    logic [3:0]         byte_cnt_reg [NB];
    logic               res_oor_reg, res_dup_reg, res_again_reg;
    logic               res_len_reg, res_once_reg, res_valid_reg;
    logic [PAIRS_W-1:0] res_pairs_reg;
    logic               out_oor_reg, out_dup_reg, out_again_reg;
    logic               out_len_reg, out_once_reg, out_valid_reg;
    logic [PAIRS_W-1:0] out_pairs_reg;
    logic [CNT_OUT_W-1:0] out_clash_reg, out_dupcnt_reg;

    logic [NUM_W-1:0]   n_eff;
    logic [NW-1:0]      a_idx, b_idx;
    logic [CW-1:0]      c_idx;
    row_t               a_hot, b_hot, row_a, row_b, col_eff, and_vec, in_use;
    logic [PADW-1:0]    and_pad;
    logic               oor, dup, before_nz, all_once;
    logic [PAIRS_W-1:0] pairs;
    logic [COUNT_WIDTH:0] clash_sum, dup_sum, placed_sum;
    logic               adj_we, col_we;
    logic [NW-1:0]      adj_waddr;
    row_t               adj_wdata, col_wdata;
    logic [SW-1:0]      clash_wide, dup_wide;

    // ------------------------------------------------------------------------
    // operand decode
    // ------------------------------------------------------------------------
    assign n_eff = (num_nodes_reg > NUM_W'(MAX_NODES)) ? NUM_W'(MAX_NODES) : num_nodes_reg;
    assign a_idx = a_reg[NW-1:0];
    assign b_idx = b_reg[NW-1:0];
    assign c_idx = c_reg[CW-1:0];
    assign a_hot = row_t'(1) << a_idx;
    assign b_hot = row_t'(1) << b_idx;
    assign row_a   = adj_a_v_reg ? adj_a_rd_reg : a_hot;
    assign row_b   = adj_b_v_reg ? adj_b_rd_reg : b_hot;
    assign col_eff = col_v_reg ? col_rd_reg : '0;
    assign and_vec = row_a & col_eff;
    assign and_pad = PADW'(and_vec);
    assign dup       = row_a[b_idx];
    assign before_nz = once_reg[a_idx] | multi_reg[a_idx];

    always_comb
    begin
        case (op_reg)
            OP_EDGE:  oor = ({1'b0, a_reg} >= n_eff) || ({1'b0, b_reg} >= n_eff);
            OP_PLACE: oor = ({1'b0, a_reg} >= n_eff) ||
                            ({1'b0, c_reg} >= NUM_W'(MAX_COLOURS));
            default:  oor = 1'b0;
        endcase
    end

    assign stat.op  = op_reg;
    assign stat.oor = oor;

    always_comb
    begin
        for (int i = 0; i < MAX_NODES; i++)
        begin
            in_use[i] = (NUM_W'(i) < n_eff);
        end
    end

    assign all_once = &(once_reg | ~in_use);

    always_comb
    begin
        pairs = '0;
        for (int j = 0; j < NB; j++)
        begin
            pairs = pairs + PAIRS_W'(byte_cnt_reg[j]);
        end
    end

    assign clash_sum  = {1'b0, clash_total_reg} + (COUNT_WIDTH+1)'(pairs);
    assign dup_sum    = {1'b0, dup_total_reg} + (COUNT_WIDTH+1)'(1);
    assign placed_sum = {1'b0, placed_total_reg} + (COUNT_WIDTH+1)'(1);

    // ------------------------------------------------------------------------
    // memory write ports
    // ------------------------------------------------------------------------
    always_comb
    begin
        adj_we    = 1'b0;
        adj_waddr = a_idx;
        adj_wdata = row_a | b_hot;
        if (cmd.exec && op_reg == OP_EDGE && !oor)
            adj_we = 1'b1;
        else if (cmd.edge2)
        begin
            adj_we    = 1'b1;
            adj_waddr = b_idx;
            adj_wdata = row_b | a_hot;
        end
    end

    assign col_we    = cmd.count;
    assign col_wdata = col_eff | a_hot;

    always_ff @(posedge clk)
    begin
        if (adj_we)
            adj_mem[adj_waddr] <= adj_wdata;
        if (col_we)
            col_mem[c_idx] <= col_wdata;
        if (cmd.capture)
        begin
            adj_a_rd_reg <= adj_mem[node_a[NW-1:0]];
            adj_b_rd_reg <= adj_mem[node_b[NW-1:0]];
            col_rd_reg   <= col_mem[colour[CW-1:0]];
        end
    end

    // ------------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------------
    always_comb
    begin
        num_nodes_next    = num_nodes_reg;
        adj_vld_next      = adj_vld_reg;
        col_vld_next      = col_vld_reg;
        once_next         = once_reg;
        multi_next        = multi_reg;
        clash_total_next  = clash_total_reg;
        dup_total_next    = dup_total_reg;
        placed_total_next = placed_total_reg;

        if (cfg_we)
            num_nodes_next = cfg_data;

        if (adj_we)
            adj_vld_next[adj_waddr] = 1'b1;

        if (cmd.exec && op_reg == OP_CLEAR)
        begin
            adj_vld_next      = '0;
            col_vld_next      = '0;
            once_next         = '0;
            multi_next        = '0;
            clash_total_next  = '0;
            dup_total_next    = '0;
            placed_total_next = '0;
        end

        if (cmd.exec && op_reg == OP_EDGE && !oor && dup)
            dup_total_next = dup_sum[COUNT_WIDTH] ? '1 : dup_sum[COUNT_WIDTH-1:0];

        if (cmd.count)
        begin
            col_vld_next[c_idx] = 1'b1;
            clash_total_next  = clash_sum[COUNT_WIDTH] ? '1 : clash_sum[COUNT_WIDTH-1:0];
            placed_total_next = placed_sum[COUNT_WIDTH] ? '1 : placed_sum[COUNT_WIDTH-1:0];
            // advance the node's placement count: none -> once -> many
            if (once_reg[a_idx])
            begin
                once_next[a_idx]  = 1'b0;
                multi_next[a_idx] = 1'b1;
            end
            else if (!multi_reg[a_idx])
                once_next[a_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_nodes_reg    <= NUM_W'(NUM_RESET);
            adj_vld_reg      <= '0;
            col_vld_reg      <= '0;
            once_reg         <= '0;
            multi_reg        <= '0;
            clash_total_reg  <= '0;
            dup_total_reg    <= '0;
            placed_total_reg <= '0;
        end
        else
        begin
            num_nodes_reg    <= num_nodes_next;
            adj_vld_reg      <= adj_vld_next;
            col_vld_reg      <= col_vld_next;
            once_reg         <= once_next;
            multi_reg        <= multi_next;
            clash_total_reg  <= clash_total_next;
            dup_total_reg    <= dup_total_next;
            placed_total_reg <= placed_total_next;
        end
    end

    // ------------------------------------------------------------------------
    // operands, results and output register
    // ------------------------------------------------------------------------
    assign clash_wide = SW'(clash_total_reg);
    assign dup_wide   = SW'(dup_total_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= op_t'(operation);
            a_reg       <= node_a;
            b_reg       <= node_b;
            c_reg       <= colour;
            adj_a_v_reg <= adj_vld_reg[node_a[NW-1:0]];
            adj_b_v_reg <= adj_vld_reg[node_b[NW-1:0]];
            col_v_reg   <= col_vld_reg[colour[CW-1:0]];
        end

        if (cmd.exec)
        begin
            res_oor_reg   <= oor;
            res_dup_reg   <= (op_reg == OP_EDGE) && !oor && dup;
            res_again_reg <= (op_reg == OP_PLACE) && !oor && before_nz;
            res_pairs_reg <= '0;
            res_len_reg   <= (op_reg == OP_CHECK) &&
                             (placed_total_reg == COUNT_WIDTH'(n_eff));
            res_once_reg  <= (op_reg == OP_CHECK) && all_once;
            res_valid_reg <= (op_reg == OP_CHECK) && all_once &&
                             (placed_total_reg == COUNT_WIDTH'(n_eff)) &&
                             (clash_total_reg == '0);
            for (int j = 0; j < NB; j++)
            begin
                byte_cnt_reg[j] <= pop8(and_pad[j*8 +: 8]);
            end
        end

        if (cmd.count)
            res_pairs_reg <= pairs;

        if (cmd.load)
        begin
            out_oor_reg    <= res_oor_reg;
            out_dup_reg    <= res_dup_reg;
            out_pairs_reg  <= res_pairs_reg;
            out_again_reg  <= res_again_reg;
            out_len_reg    <= res_len_reg;
            out_once_reg   <= res_once_reg;
            out_valid_reg  <= res_valid_reg;
            out_clash_reg  <= (clash_wide > SW'(CNT_OUT_MAX)) ? '1 : clash_wide[CNT_OUT_W-1:0];
            out_dupcnt_reg <= (dup_wide > SW'(CNT_OUT_MAX)) ? '1 : dup_wide[CNT_OUT_W-1:0];
        end
    end

    assign out_of_range         = out_oor_reg;
    assign duplicate_edge       = out_dup_reg;
    assign conflict_pairs       = out_pairs_reg;
    assign placed_again         = out_again_reg;
    assign length_ok            = out_len_reg;
    assign each_once_ok         = out_once_reg;
    assign colouring_valid      = out_valid_reg;
    assign clash_count          = out_clash_reg;
    assign duplicate_edge_count = out_dupcnt_reg;

endmodule

/* rtl/graph_colouring_checker_top.sv */
// ----------------------------------------------------------------------------
// graph_colouring_checker_top
// Adjacency matrix keeper and vertex colouring checker.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    operation, node_a, node_b, colour
//   out      source     out_valid / out_stall  nine result fields
//   cfg      sink       cfg_valid / cfg_ready  cfg_data (num_nodes)
//
// One word at a time: clear and check pass capture, execute and done; add
// edge and place add a step (two row writes through the single adjacency
// write port, or a popcount stage before the colour row write). A new word
// is taken while the previous result still sits in the output register.
// Reset clears the row valid bits at once, so no clearing pass.
// ----------------------------------------------------------------------------
module graph_colouring_checker_top
    import gcc_pkg::*;
#(
    parameter int MAX_NODES   = 64,
    parameter int MAX_COLOURS = 64,
    parameter int COUNT_WIDTH = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           operation,
    input  logic [ID_W-1:0]      node_a,
    input  logic [ID_W-1:0]      node_b,
    input  logic [ID_W-1:0]      colour,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 out_of_range,
    output logic                 duplicate_edge,
    output logic [PAIRS_W-1:0]   conflict_pairs,
    output logic                 placed_again,
    output logic                 length_ok,
    output logic                 each_once_ok,
    output logic                 colouring_valid,
    output logic [CNT_OUT_W-1:0] clash_count,
    output logic [CNT_OUT_W-1:0] duplicate_edge_count,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [NUM_W-1:0]     cfg_data
);

    gcc_cmd_t  cmd;
    gcc_stat_t stat;

    gcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    gcc_dp #(
        .MAX_NODES   (MAX_NODES),
        .MAX_COLOURS (MAX_COLOURS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .stat                 (stat),
        .cfg_we               (cfg_valid && cfg_ready),
        .cfg_data             (cfg_data),
        .operation            (operation),
        .node_a               (node_a),
        .node_b               (node_b),
        .colour               (colour),
        .out_of_range         (out_of_range),
        .duplicate_edge       (duplicate_edge),
        .conflict_pairs       (conflict_pairs),
        .placed_again         (placed_again),
        .length_ok            (length_ok),
        .each_once_ok         (each_once_ok),
        .colouring_valid      (colouring_valid),
        .clash_count          (clash_count),
        .duplicate_edge_count (duplicate_edge_count)
    );

    // only one word in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second word accepted while one is in flight");

    // a result is only loaded from the finishing step of a word
    a_result_after_word: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a word in progress");

    // a rejected word reports nothing but the flag and the totals
    a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |-> (!duplicate_edge && !placed_again &&
            conflict_pairs == '0 && !length_ok && !each_once_ok && !colouring_valid))
        else $error("out of range result carries operation fields");

endmodule

/* tb/sv/graph_colouring_checker_top_test.sv */
// ----------------------------------------------------------------------------
// graph_colouring_checker_top_test
// Self-checking bench for the graph colouring checker. A behavioral copy of
// the adjacency matrix, colour rows and placement counters predicts every
// result word. Directed cases come first. Counter saturation is next. Then
// random colouring rounds run under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module graph_colouring_checker_top_test;

    import gcc_pkg::*;

    localparam int NODES         = 64;
    localparam int COLOURS       = 64;
    localparam int SETTLE_CYCLES = 10;
    localparam int ROUND_WORDS   = 120;

    typedef struct packed {
        logic                 range_err;
        logic                 dup_edge;
        logic [PAIRS_W-1:0]   pairs;
        logic                 again;
        logic                 length_pass;
        logic                 once_pass;
        logic                 colouring_pass;
        logic [CNT_OUT_W-1:0] clashes;
        logic [CNT_OUT_W-1:0] duplicates;
    } verdict_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [1:0]           operation = OP_CLEAR;
    logic [ID_W-1:0]      node_a    = '0;
    logic [ID_W-1:0]      node_b    = '0;
    logic [ID_W-1:0]      colour    = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 out_of_range;
    logic                 duplicate_edge;
    logic [PAIRS_W-1:0]   conflict_pairs;
    logic                 placed_again;
    logic                 length_ok;
    logic                 each_once_ok;
    logic                 colouring_valid;
    logic [CNT_OUT_W-1:0] clash_count;
    logic [CNT_OUT_W-1:0] duplicate_edge_count;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [NUM_W-1:0]     cfg_data  = '0;

    // behavioral copy of the block state
    logic [NODES-1:0]     adj_rows [NODES];
    logic [NODES-1:0]     colour_rows [COLOURS];
    logic [1:0]           place_cnt [NODES];
    int unsigned          placed_sum;
    int unsigned          clash_sum;
    int unsigned          dup_sum;
    logic [NUM_W-1:0]     node_limit;

    verdict_t             verdict_q [$];
    int unsigned          fail_count = 0;
    int                   sender_idle_pct = 0;
    int                   receiver_stall_pct = 0;

    graph_colouring_checker_top u_dut
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .operation            (operation),
        .node_a               (node_a),
        .node_b               (node_b),
        .colour               (colour),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .out_of_range         (out_of_range),
        .duplicate_edge       (duplicate_edge),
        .conflict_pairs       (conflict_pairs),
        .placed_again         (placed_again),
        .length_ok            (length_ok),
        .each_once_ok         (each_once_ok),
        .colouring_valid      (colouring_valid),
        .clash_count          (clash_count),
        .duplicate_edge_count (duplicate_edge_count),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_data             (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic int unsigned sat_total(int unsigned v);
        return (v > CNT_OUT_MAX) ? CNT_OUT_MAX : v;
    endfunction

    function automatic void clear_graph_state();
        for (int i = 0; i < NODES; i++)
        begin
            adj_rows[i]  = '0;
            adj_rows[i][i] = 1'b1;
            place_cnt[i] = '0;
        end
        for (int i = 0; i < COLOURS; i++)
        begin
            colour_rows[i] = '0;
        end
        placed_sum = 0;
        clash_sum  = 0;
        dup_sum    = 0;
    endfunction

    function automatic verdict_t predict_colouring(op_t op, logic [ID_W-1:0] a,
                                                   logic [ID_W-1:0] b,
                                                   logic [ID_W-1:0] c);
        verdict_t v;
        int       n;
        int       k;
        bit       once;
        v = '0;
        n = (node_limit > NODES) ? NODES : int'(node_limit);
        case (op)
            OP_CLEAR:
            begin
                clear_graph_state();
            end
            OP_EDGE:
            begin
                if (a >= n || b >= n)
                begin
                    v.range_err = 1'b1;
                end
                else
                begin
                    if (adj_rows[a][b])
                    begin
                        v.dup_edge = 1'b1;
                        dup_sum = sat_total(dup_sum + 1);
                    end
                    adj_rows[a][b] = 1'b1;
                    adj_rows[b][a] = 1'b1;
                end
            end
            OP_PLACE:
            begin
                if (a >= n || c >= COLOURS)
                begin
                    v.range_err = 1'b1;
                end
                else
                begin
                    k = $countones(adj_rows[a] & colour_rows[c]);
                    v.pairs = PAIRS_W'(k);
                    v.again = (place_cnt[a] != 0);
                    clash_sum = sat_total(clash_sum + k);
                    colour_rows[c][a] = 1'b1;
                    if (place_cnt[a] != 2'd3)
                    begin
                        place_cnt[a] = place_cnt[a] + 2'd1;
                    end
                    placed_sum = sat_total(placed_sum + 1);
                end
            end
            default:
            begin
                once = 1'b1;
                for (int i = 0; i < n; i++)
                begin
                    if (place_cnt[i] != 2'd1)
                    begin
                        once = 1'b0;
                    end
                end
                v.length_pass    = (placed_sum == n);
                v.once_pass      = once;
                v.colouring_pass = v.length_pass && once && (clash_sum == 0);
            end
        endcase
        v.clashes    = CNT_OUT_W'(clash_sum);
        v.duplicates = CNT_OUT_W'(dup_sum);
        return v;
    endfunction

    // pick a colour with no neighbour of the node in it, from a random start
    function automatic logic [ID_W-1:0] free_colour(logic [ID_W-1:0] node);
        int start;
        int c;
        start = $urandom_range(COLOURS - 1);
        for (int i = 0; i < COLOURS; i++)
        begin
            c = (start + i) % COLOURS;
            if ((adj_rows[node] & colour_rows[c]) == '0)
            begin
                return ID_W'(c);
            end
        end
        return ID_W'(start);
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------
    task automatic send_word(op_t op, logic [ID_W-1:0] a, logic [ID_W-1:0] b,
                             logic [ID_W-1:0] c);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
            begin
                @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        operation <= op;
        node_a    <= a;
        node_b    <= b;
        colour    <= c;
        @(posedge clk);
        while (in_stall !== 1'b0)
        begin
            @(posedge clk);
        end
        verdict_q = {verdict_q, predict_colouring(op, a, b, c)};
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_node_limit(logic [NUM_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
        begin
            @(posedge clk);
        end
        cfg_valid  <= 1'b0;
        node_limit = value;
    endtask

    task automatic send_noise(inout int sent);
        send_word(op_t'($urandom_range(3)), ID_W'($urandom_range(63)),
                  ID_W'($urandom_range(63)), ID_W'($urandom_range(63)));
        sent++;
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(string name, logic [CNT_OUT_W-1:0] got,
                               logic [CNT_OUT_W-1:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                report_mismatch("result word with nothing outstanding");
            end
            else
            begin
                want = verdict_q.pop_front();
                check_field("out_of_range", CNT_OUT_W'(out_of_range),
                            CNT_OUT_W'(want.range_err));
                check_field("duplicate_edge", CNT_OUT_W'(duplicate_edge),
                            CNT_OUT_W'(want.dup_edge));
                check_field("conflict_pairs", CNT_OUT_W'(conflict_pairs),
                            CNT_OUT_W'(want.pairs));
                check_field("placed_again", CNT_OUT_W'(placed_again),
                            CNT_OUT_W'(want.again));
                check_field("length_ok", CNT_OUT_W'(length_ok),
                            CNT_OUT_W'(want.length_pass));
                check_field("each_once_ok", CNT_OUT_W'(each_once_ok),
                            CNT_OUT_W'(want.once_pass));
                check_field("colouring_valid", CNT_OUT_W'(colouring_valid),
                            CNT_OUT_W'(want.colouring_pass));
                check_field("clash_count", clash_count, want.clashes);
                check_field("duplicate_edge_count", duplicate_edge_count,
                            want.duplicates);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_word(OP_CHECK, 6'd0, 6'd0, 6'd0);
        send_word(OP_EDGE, 6'd0, 6'd63, 6'd0);
        // same edge reversed, then a self loop on the diagonal
        send_word(OP_EDGE, 6'd63, 6'd0, 6'd63);
        send_word(OP_EDGE, 6'd5, 6'd5, 6'd0);
        send_word(OP_PLACE, 6'd0, 6'd0, 6'd0);
        send_word(OP_PLACE, 6'd63, 6'd63, 6'd0);
        send_word(OP_PLACE, 6'd0, 6'd0, 6'd63);
        // same node twice in one colour clashes with itself
        send_word(OP_PLACE, 6'd0, 6'd0, 6'd0);
        send_word(OP_CHECK, 6'd63, 6'd63, 6'd63);

        // clashes are judged at placement time only
        write_node_limit(7'd2);
        send_word(OP_CLEAR, 6'd0, 6'd0, 6'd0);
        send_word(OP_PLACE, 6'd0, 6'd0, 6'd1);
        send_word(OP_PLACE, 6'd1, 6'd0, 6'd1);
        send_word(OP_EDGE, 6'd0, 6'd1, 6'd0);
        send_word(OP_CHECK, 6'd0, 6'd0, 6'd0);
        send_word(OP_EDGE, 6'd1, 6'd2, 6'd0);
        send_word(OP_PLACE, 6'd2, 6'd0, 6'd1);

        // empty graph: every id is out of range
        write_node_limit(7'd0);
        send_word(OP_EDGE, 6'd0, 6'd0, 6'd0);
        send_word(OP_PLACE, 6'd0, 6'd0, 6'd0);
        send_word(OP_CLEAR, 6'd63, 6'd63, 6'd63);
        send_word(OP_CHECK, 6'd0, 6'd0, 6'd0);

        // limits above the node count act as the full graph
        write_node_limit(7'd127);
        send_word(OP_EDGE, 6'd63, 6'd62, 6'd0);
        send_word(OP_PLACE, 6'd63, 6'd0, 6'd63);

        write_node_limit(7'd1);
        send_word(OP_CLEAR, 6'd0, 6'd0, 6'd0);
        send_word(OP_PLACE, 6'd0, 6'd0, 6'd5);
        send_word(OP_CHECK, 6'd0, 6'd0, 6'd0);
    endtask

    task automatic test_counter_saturation();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        write_node_limit(7'd64);
        send_word(OP_CLEAR, 6'd0, 6'd0, 6'd0);
        // star around node 0, leaves all in one colour
        for (int i = 1; i < NODES; i++)
        begin
            send_word(OP_EDGE, 6'd0, ID_W'(i), ID_W'($urandom_range(63)));
        end
        for (int i = 1; i < NODES; i++)
        begin
            send_word(OP_PLACE, ID_W'(i), ID_W'($urandom_range(63)), 6'd7);
        end
        // the hub now sees every member: full conflict count, clash total saturates
        repeat (66)
        begin
            send_word(OP_PLACE, 6'd0, ID_W'($urandom_range(63)), 6'd7);
        end
        send_word(OP_CHECK, 6'd0, 6'd0, 6'd0);
        repeat (40)
        begin
            send_word(OP_EDGE, 6'd9, 6'd9, ID_W'($urandom_range(63)));
        end
        send_word(OP_CHECK, 6'd0, 6'd0, 6'd0);
        send_word(OP_CLEAR, 6'd0, 6'd0, 6'd0);
        send_word(OP_CHECK, 6'd0, 6'd0, 6'd0);
    endtask

    task automatic run_colouring_round(inout int sent);
        int              n;
        int              edge_total;
        int              j;
        int              tmp;
        int              order [$];
        logic [ID_W-1:0] c;
        if ($urandom_range(2) == 0)
        begin
            case ($urandom_range(9))
                0:       write_node_limit(7'd0);
                1:       write_node_limit(NUM_W'($urandom_range(127, 65)));
                2:       write_node_limit(7'd64);
                3:       write_node_limit(NUM_W'($urandom_range(63, 13)));
                default: write_node_limit(NUM_W'($urandom_range(12, 1)));
            endcase
        end
        n = (node_limit > NODES) ? NODES : int'(node_limit);
        send_word(OP_CLEAR, ID_W'($urandom_range(63)), ID_W'($urandom_range(63)),
                  ID_W'($urandom_range(63)));
        sent++;
        if (n == 0)
        begin
            repeat (6) send_noise(sent);
            return;
        end
        edge_total = $urandom_range(2 * n);
        repeat (edge_total)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_noise(sent);
            end
            send_word(OP_EDGE, ID_W'($urandom_range(n - 1)), ID_W'($urandom_range(n - 1)),
                      ID_W'($urandom_range(63)));
            sent++;
        end
        for (int i = 0; i < n; i++)
        begin
            order = {order, i};
        end
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i])
        begin
            if ($urandom_range(9) == 0)
            begin
                send_noise(sent);
            end
            // skip a node now and then, or place it twice
            if ($urandom_range(15) != 0)
            begin
                c = ($urandom_range(3) != 0) ? free_colour(ID_W'(order[i])) :
                                               ID_W'($urandom_range(63));
                send_word(OP_PLACE, ID_W'(order[i]), ID_W'($urandom_range(63)), c);
                sent++;
            end
            if ($urandom_range(15) == 0)
            begin
                send_word(OP_PLACE, ID_W'(order[i]), ID_W'($urandom_range(63)),
                          ID_W'($urandom_range(63)));
                sent++;
            end
        end
        send_word(OP_CHECK, ID_W'($urandom_range(63)), ID_W'($urandom_range(63)),
                  ID_W'($urandom_range(63)));
        sent++;
    endtask

    task automatic test_random_phases();
        int idle_mix [4]  = '{0, 79, 0, 23};
        int stall_mix [4] = '{0, 0, 79, 23};
        int sent;
        for (int p = 0; p < 4; p++)
        begin
            sender_idle_pct    = idle_mix[p];
            receiver_stall_pct = stall_mix[p];
            sent = 0;
            while (sent < ROUND_WORDS)
            begin
                run_colouring_round(sent);
            end
        end
    endtask

    initial
    begin
        node_limit = NUM_RESET;
        clear_graph_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_counter_saturation();
        test_random_phases();
        drain_results();
        if (fail_count == 0)
        begin
            $display("graph_colouring_checker_top verification clean");
        end
        else
        begin
            $display("graph_colouring_checker_top verification failed");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("graph_colouring_checker_top verification failed");
        $finish;
    end

endmodule
